/* design/query_language_tokenizer_defines.svh */
// assertion macros for the query language tokenizer
`ifndef QUERY_LANGUAGE_TOKENIZER_DEFINES_SVH
`define QUERY_LANGUAGE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define QLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define QLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define QLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/qlt_pkg.sv */
// shared types, token codes and keyword table of the query language tokenizer
package qlt_pkg;

	localparam int KW_CHARS = 8;
	localparam int POS_W = 16;
	localparam int KW_IDX_W = (KW_CHARS > 1) ? $clog2(KW_CHARS) : 1;
	localparam int KW_COUNT = 22;
	localparam int KW_TEXT_CHARS = 8;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [5:0] K_DOT     = 6'd0;
	localparam logic [5:0] K_SLASH   = 6'd1;
	localparam logic [5:0] K_COMMA   = 6'd2;
	localparam logic [5:0] K_LPAREN  = 6'd3;
	localparam logic [5:0] K_RPAREN  = 6'd4;
	localparam logic [5:0] K_LT      = 6'd5;
	localparam logic [5:0] K_LE      = 6'd6;
	localparam logic [5:0] K_GT      = 6'd7;
	localparam logic [5:0] K_GE      = 6'd8;
	localparam logic [5:0] K_EQ      = 6'd9;
	localparam logic [5:0] K_NE      = 6'd10;
	localparam logic [5:0] K_STRING  = 6'd11;
	localparam logic [5:0] K_NUMBER  = 6'd12;
	localparam logic [5:0] K_IDENT   = 6'd13;
	localparam logic [5:0] K_KW0     = 6'd14;
	localparam logic [5:0] K_INVALID = 6'd36;
	localparam logic [5:0] K_END     = 6'd37;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_NUMBER,
		M_STRING,
		M_LT,
		M_GT,
		M_BANG
	} mode_t;

	typedef logic [KW_CHARS-1:0][6:0] kw_arr_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] n;
		tok_t       t0;
		tok_t       t1;
	} push_t;

	// keyword text, left aligned and padded with spaces
	function automatic logic [8*KW_TEXT_CHARS-1:0] kw_text(input int k);
		case (k)
			0:  kw_text = "SELECT  ";
			1:  kw_text = "FROM    ";
			2:  kw_text = "WHERE   ";
			3:  kw_text = "AND     ";
			4:  kw_text = "OR      ";
			5:  kw_text = "ORDER   ";
			6:  kw_text = "BY      ";
			7:  kw_text = "LIMIT   ";
			8:  kw_text = "ASC     ";
			9:  kw_text = "DESC    ";
			10: kw_text = "IS      ";
			11: kw_text = "NOT     ";
			12: kw_text = "NULL    ";
			13: kw_text = "LIKE    ";
			14: kw_text = "SET     ";
			15: kw_text = "SHOW    ";
			16: kw_text = "XSD     ";
			17: kw_text = "DEST    ";
			18: kw_text = "GENERATE";
			19: kw_text = "XML     ";
			20: kw_text = "PREFIX  ";
			21: kw_text = "CHECK   ";
			default: kw_text = "        ";
		endcase
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		case (k)
			0, 20:                kw_len = 4'd6;
			1, 9, 12, 13, 15, 17: kw_len = 4'd4;
			2, 5, 7, 21:          kw_len = 4'd5;
			3, 8, 11, 14, 16, 19: kw_len = 4'd3;
			4, 6, 10:             kw_len = 4'd2;
			18:                   kw_len = 4'd8;
			default:              kw_len = 4'd0;
		endcase
	endfunction

	// parallel compare of the held characters against every keyword
	function automatic logic [5:0] kw_match(input kw_arr_t chars, input logic [POS_W-1:0] len);
		logic [8*KW_TEXT_CHARS-1:0] w;
		logic [3:0] l;
		logic hit;
		logic [5:0] res;
		res = K_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			w = kw_text(k);
			l = kw_len(k);
			hit = (len == POS_W'(l));
			for (int i = 0; i < KW_TEXT_CHARS; i++) begin
				if ((i < int'(l)) && (i < KW_CHARS)) begin
					if (chars[KW_IDX_W'(i)] != w[(KW_TEXT_CHARS-1-i)*8 +: 7])
						hit = 1'b0;
				end
			end
			if (hit)
				res = K_KW0 + 6'(k);
		end
		return res;
	endfunction

	// position or length value as a 16 bit field
	function automatic logic [15:0] to_field(input logic [POS_W-1:0] v);
		logic [POS_W+15:0] ext;
		ext = {16'b0, v};
		return ext[15:0];
	endfunction

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
		return (v == POS_MAX) ? v : v + POS_W'(1);
	endfunction

endpackage

/* design/qlt_lexer.sv */
// lexer state and the per-byte token logic
module qlt_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              cmd,
	input  logic [7:0]        ch,
	output qlt_pkg::push_t    push
);

	qlt_pkg::mode_t              mode_q, mode_d;
	logic                        dq_q, dq_d;
	logic [qlt_pkg::POS_W-1:0]   start_q, start_d;
	logic [qlt_pkg::POS_W-1:0]   len_q, len_d;
	logic [qlt_pkg::POS_W-1:0]   pos_q, pos_d;
	logic                        long_q, long_d;
	qlt_pkg::kw_arr_t            kw_q, kw_d;

	logic        is_digit, is_alpha, is_space, is_ident;
	logic [6:0]  upper;
	logic [5:0]  ident_kind;
	qlt_pkg::tok_t ta, tb, tc;
	logic        va, vb, vc, consumed;

	assign is_digit = (ch >= "0") && (ch <= "9");
	assign is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
	assign is_space = (ch == " ") || ((ch >= 8'd9) && (ch <= 8'd13));
	assign is_ident = is_alpha || is_digit || (ch == "_");
	assign upper    = ((ch >= "a") && (ch <= "z")) ? 7'(ch - 8'd32) : ch[6:0];

	assign ident_kind = (long_q || (len_q > qlt_pkg::POS_W'(qlt_pkg::KW_CHARS))) ?
		qlt_pkg::K_IDENT : qlt_pkg::kw_match(kw_q, len_q);

	always_comb begin
		mode_d   = mode_q;
		dq_d     = dq_q;
		start_d  = start_q;
		len_d    = len_q;
		pos_d    = pos_q;
		long_d   = long_q;
		kw_d     = kw_q;
		consumed = 1'b0;
		va = 1'b0;
		vc = 1'b0;
		ta = '0;
		tc = '0;

		// token that the current mode flushes
		vb = (mode_q != qlt_pkg::M_IDLE);
		tb = '0;
		tb.start = qlt_pkg::to_field(start_q);
		tb.len   = qlt_pkg::to_field(len_q);
		case (mode_q)
			qlt_pkg::M_IDENT:  tb.kind = ident_kind;
			qlt_pkg::M_NUMBER: tb.kind = qlt_pkg::K_NUMBER;
			qlt_pkg::M_STRING: tb.kind = qlt_pkg::K_INVALID;
			qlt_pkg::M_LT: begin
				tb.kind = qlt_pkg::K_LT;
				tb.len  = 16'd1;
			end
			qlt_pkg::M_GT: begin
				tb.kind = qlt_pkg::K_GT;
				tb.len  = 16'd1;
			end
			qlt_pkg::M_BANG: begin
				tb.kind = qlt_pkg::K_INVALID;
				tb.len  = 16'd1;
			end
			default: tb.kind = qlt_pkg::K_INVALID;
		endcase

		if (cmd) begin
			vc       = 1'b1;
			tc.kind  = qlt_pkg::K_END;
			tc.start = qlt_pkg::to_field(pos_q);
			tc.len   = 16'd0;
			mode_d   = qlt_pkg::M_IDLE;
			pos_d    = '0;
		end else begin
			case (mode_q)
				qlt_pkg::M_STRING: begin
					consumed = 1'b1;
					if (ch == (dq_q ? 8'h22 : 8'h27)) begin
						va       = 1'b1;
						ta.kind  = qlt_pkg::K_STRING;
						ta.start = qlt_pkg::to_field(start_q);
						ta.len   = qlt_pkg::to_field(len_q);
						mode_d   = qlt_pkg::M_IDLE;
					end else begin
						len_d = qlt_pkg::sat_inc(len_q);
					end
				end
				qlt_pkg::M_IDENT: begin
					if (is_ident) begin
						consumed = 1'b1;
						if (len_q < qlt_pkg::POS_W'(qlt_pkg::KW_CHARS))
							kw_d[len_q[qlt_pkg::KW_IDX_W-1:0]] = upper;
						else
							long_d = 1'b1;
						len_d = qlt_pkg::sat_inc(len_q);
					end
				end
				qlt_pkg::M_NUMBER: begin
					if (is_digit || (ch == ".")) begin
						consumed = 1'b1;
						len_d    = qlt_pkg::sat_inc(len_q);
					end
				end
				qlt_pkg::M_LT, qlt_pkg::M_GT, qlt_pkg::M_BANG: begin
					if (ch == "=") begin
						consumed = 1'b1;
						va       = 1'b1;
						ta.start = qlt_pkg::to_field(start_q);
						ta.len   = 16'd2;
						if (mode_q == qlt_pkg::M_LT)
							ta.kind = qlt_pkg::K_LE;
						else if (mode_q == qlt_pkg::M_GT)
							ta.kind = qlt_pkg::K_GE;
						else
							ta.kind = qlt_pkg::K_NE;
						mode_d = qlt_pkg::M_IDLE;
					end
				end
				default: ;
			endcase

			if (consumed) begin
				vb = 1'b0;
			end else begin
				// flush, then treat the byte as the first of a new token
				mode_d   = qlt_pkg::M_IDLE;
				tc.start = qlt_pkg::to_field(pos_q);
				tc.len   = 16'd1;
				tc.kind  = qlt_pkg::K_INVALID;
				if (!is_space) begin
					case (ch)
						".": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_DOT;
						end
						"/": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_SLASH;
						end
						",": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_COMMA;
						end
						"(": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_LPAREN;
						end
						")": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_RPAREN;
						end
						"=": begin
							vc      = 1'b1;
							tc.kind = qlt_pkg::K_EQ;
						end
						"<": begin
							mode_d  = qlt_pkg::M_LT;
							start_d = pos_q;
							len_d   = '0;
						end
						">": begin
							mode_d  = qlt_pkg::M_GT;
							start_d = pos_q;
							len_d   = '0;
						end
						"!": begin
							mode_d  = qlt_pkg::M_BANG;
							start_d = pos_q;
							len_d   = '0;
						end
						8'h22, 8'h27: begin
							mode_d  = qlt_pkg::M_STRING;
							start_d = pos_q;
							len_d   = '0;
							dq_d    = (ch == 8'h22);
						end
						default: begin
							if (is_digit) begin
								mode_d  = qlt_pkg::M_NUMBER;
								start_d = pos_q;
								len_d   = qlt_pkg::POS_W'(1);
							end else if (is_alpha || (ch == "_")) begin
								mode_d   = qlt_pkg::M_IDENT;
								start_d  = pos_q;
								len_d    = qlt_pkg::POS_W'(1);
								long_d   = 1'b0;
								kw_d[0]  = upper;
							end else begin
								vc = 1'b1;
							end
						end
					endcase
				end
			end
			pos_d = qlt_pkg::sat_inc(pos_q);
		end

		// at most two tokens: a consumed-byte token alone, or flush then new or end
		push.t0 = va ? ta : (vb ? tb : tc);
		push.t1 = tc;
		push.n  = va ? 2'd1 : (2'({1'b0, vb}) + 2'({1'b0, vc}));
		push.t0.last = (push.n == 2'd1);
		push.t1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= qlt_pkg::M_IDLE;
			dq_q    <= 1'b0;
			start_q <= '0;
			len_q   <= '0;
			pos_q   <= '0;
			long_q  <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			dq_q    <= dq_d;
			start_q <= start_d;
			len_q   <= len_d;
			pos_q   <= pos_d;
			long_q  <= long_d;
		end
	end

	// keyword characters are only read below the written length
	always_ff @(posedge clk) begin
		if (en)
			kw_q <= kw_d;
	end

endmodule

/* design/qlt_tok_queue.sv */
// three-entry token queue, head entry drives the output channel
module qlt_tok_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_en,
	input  qlt_pkg::push_t  push,
	output logic [1:0]      room,
	output logic            out_valid,
	input  logic            out_ready,
	output qlt_pkg::tok_t   head
);

	localparam int DEPTH = 3;

	qlt_pkg::tok_t        q_q [DEPTH];
	qlt_pkg::tok_t        q_d [DEPTH];
	logic [1:0]           count_q, count_d;
	logic                 pop;
	logic [2:0]           base;
	logic [2:0]           grow;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign head      = q_q[0];
	assign base      = 3'(count_q) - 3'(pop);
	assign room      = 2'(3'(DEPTH) - base);
	assign grow      = push_en ? 3'(push.n) : 3'd0;
	assign count_d   = 2'(base + grow);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (pop && (i < DEPTH - 1))
				q_d[i] = q_q[i+1];
			else
				q_d[i] = q_q[i];
			if (push_en && (push.n != 2'd0) && (base == 3'(i)))
				q_d[i] = push.t0;
			if (push_en && (push.n == 2'd2) && ((base + 3'd1) == 3'(i)))
				q_d[i] = push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= 2'd0;
		else
			count_q <= count_d;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++)
			q_q[i] <= q_d[i];
	end

endmodule

/* design/query_language_tokenizer.sv */
// top level of the query language tokenizer
// Streaming lexer for a small SQL-like query language.
// Input channel (in_valid/in_ready): one item per byte of text with cmd = 0
// and the byte in ch, then one item with cmd = 1 to end the text.
// Output channel (out_valid/out_ready): tokens as kind, start_res, length;
// last marks the final token caused by one input item.
// An accepted item is held in the input register until its tokens fit in
// the token queue; they are then written into the queue, and the first
// one is presented on the output from the queue's head entry.
// Throughput: one item per cycle while the output is taken every cycle;
// an item that yields two tokens (flush plus new token, or flush plus end)
// needs two transfers on the single output port of the three-entry token
// queue.
// A stalled receiver fills the queue; the input register then holds its
// item and in_ready drops, with nothing lost.
// Reset: lexer idle, byte position zero, queue and input register empty.
// After the end item the next byte starts a new text at offset zero.
`include "query_language_tokenizer_defines.svh"

module query_language_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  kind,
	output logic [15:0] start_res,
	output logic [15:0] length,
	output logic        last
);

	logic           valid_s1;
	logic           cmd_s1;
	logic [7:0]     ch_s1;
	logic           take;
	logic [1:0]     room;
	qlt_pkg::push_t push;
	qlt_pkg::tok_t  head;

	// item leaves the input register once its tokens fit in the queue
	assign take     = valid_s1 && (push.n <= room);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			ch_s1  <= ch;
		end
	end

	qlt_lexer u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (take),
		.cmd    (cmd_s1),
		.ch     (ch_s1),
		.push   (push)
	);

	qlt_tok_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (take),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign kind      = head.kind;
	assign start_res = head.start;
	assign length    = head.len;
	assign last      = head.last;

	`QLT_ASSERT_NOW(a_end_is_last, clk, arst_n, take && cmd_s1, (push.n == 2'd1 && push.t0.kind == qlt_pkg::K_END) || (push.n == 2'd2 && push.t1.kind == qlt_pkg::K_END), "end item must close with an end token")
	`QLT_ASSERT_NOW(a_no_early_end, clk, arst_n, take && (push.n == 2'd2), push.t0.kind != qlt_pkg::K_END, "end token ahead of another token")
	`QLT_ASSERT_NEXT(a_input_held, clk, arst_n, in_valid && in_ready, valid_s1, "accepted item missing from input register")

endmodule

/* tb/tokenizer_checker.sv */
// token predictor and comparator for the query language tokenizer testbench
`timescale 1ns / 100ps

module tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  ch,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [5:0]  kind,
	input  logic [15:0] start_res,
	input  logic [15:0] length,
	input  logic        last,
	output int          errors,
	output int          pending
);

	localparam logic CMD_END = 1'b1;
	localparam logic [qlt_pkg::POS_W-1:0] NO_CHARS  = qlt_pkg::POS_W'(0);
	localparam logic [qlt_pkg::POS_W-1:0] ONE_CHAR  = qlt_pkg::POS_W'(1);
	localparam logic [qlt_pkg::POS_W-1:0] TWO_CHARS = qlt_pkg::POS_W'(2);

	// lexer state as the block should hold it
	qlt_pkg::mode_t            lex_mode;
	bit                        quote_dbl;
	logic [qlt_pkg::POS_W-1:0] tok_start;
	logic [qlt_pkg::POS_W-1:0] tok_len;
	logic [qlt_pkg::POS_W-1:0] byte_pos;
	logic [6:0]                word_chars [qlt_pkg::KW_CHARS];
	bit                        too_long;

	qlt_pkg::tok_t expected_toks[$];
	qlt_pkg::tok_t item_toks[2];
	int            item_tok_cnt;

	function automatic string keyword_spelling(input int k);
		case (k)
			0:  return "SELECT";
			1:  return "FROM";
			2:  return "WHERE";
			3:  return "AND";
			4:  return "OR";
			5:  return "ORDER";
			6:  return "BY";
			7:  return "LIMIT";
			8:  return "ASC";
			9:  return "DESC";
			10: return "IS";
			11: return "NOT";
			12: return "NULL";
			13: return "LIKE";
			14: return "SET";
			15: return "SHOW";
			16: return "XSD";
			17: return "DEST";
			18: return "GENERATE";
			19: return "XML";
			20: return "PREFIX";
			default: return "CHECK";
		endcase
	endfunction

	function automatic logic [qlt_pkg::POS_W-1:0] bump(input logic [qlt_pkg::POS_W-1:0] v);
		return (v == qlt_pkg::POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [5:0] classify_word();
		string s;
		bit hit;
		if (too_long || tok_len > qlt_pkg::KW_CHARS)
			return qlt_pkg::K_IDENT;
		for (int k = 0; k < qlt_pkg::KW_COUNT; k++) begin
			s = keyword_spelling(k);
			if (s.len() == int'(tok_len)) begin
				hit = 1'b1;
				for (int i = 0; i < s.len(); i++)
					if ({1'b0, word_chars[i]} != 8'(s[i]))
						hit = 1'b0;
				if (hit)
					return qlt_pkg::K_KW0 + 6'(k);
			end
		end
		return qlt_pkg::K_IDENT;
	endfunction

	task automatic add_tok(input logic [5:0] k, input logic [qlt_pkg::POS_W-1:0] s,
			input logic [qlt_pkg::POS_W-1:0] n);
		qlt_pkg::tok_t t;
		t.kind = k;
		t.start = 16'(s);
		t.len = 16'(n);
		t.last = 1'b0;
		item_toks[item_tok_cnt] = t;
		item_tok_cnt++;
	endtask

	task automatic append_word_char(input logic [7:0] c);
		logic [7:0] u;
		u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		if (tok_len < qlt_pkg::KW_CHARS)
			word_chars[int'(tok_len)] = u[6:0];
		else
			too_long = 1'b1;
		tok_len = bump(tok_len);
	endtask

	task automatic begin_token(input qlt_pkg::mode_t m);
		lex_mode = m;
		tok_start = byte_pos;
		tok_len = NO_CHARS;
	endtask

	task automatic flush_token();
		case (lex_mode)
			qlt_pkg::M_IDENT:  add_tok(classify_word(), tok_start, tok_len);
			qlt_pkg::M_NUMBER: add_tok(qlt_pkg::K_NUMBER, tok_start, tok_len);
			qlt_pkg::M_STRING: add_tok(qlt_pkg::K_INVALID, tok_start, tok_len);
			qlt_pkg::M_LT:     add_tok(qlt_pkg::K_LT, tok_start, ONE_CHAR);
			qlt_pkg::M_GT:     add_tok(qlt_pkg::K_GT, tok_start, ONE_CHAR);
			qlt_pkg::M_BANG:   add_tok(qlt_pkg::K_INVALID, tok_start, ONE_CHAR);
			default: ;
		endcase
		lex_mode = qlt_pkg::M_IDLE;
	endtask

	task automatic idle_char(input logic [7:0] c);
		if (c == " " || (c >= 8'd9 && c <= 8'd13))
			return;
		case (c)
			".": add_tok(qlt_pkg::K_DOT, byte_pos, ONE_CHAR);
			"/": add_tok(qlt_pkg::K_SLASH, byte_pos, ONE_CHAR);
			",": add_tok(qlt_pkg::K_COMMA, byte_pos, ONE_CHAR);
			"(": add_tok(qlt_pkg::K_LPAREN, byte_pos, ONE_CHAR);
			")": add_tok(qlt_pkg::K_RPAREN, byte_pos, ONE_CHAR);
			"=": add_tok(qlt_pkg::K_EQ, byte_pos, ONE_CHAR);
			"<": begin_token(qlt_pkg::M_LT);
			">": begin_token(qlt_pkg::M_GT);
			"!": begin_token(qlt_pkg::M_BANG);
			"\"", "'": begin
				begin_token(qlt_pkg::M_STRING);
				quote_dbl = (c == "\"");
			end
			default: begin
				if (is_digit(c)) begin
					begin_token(qlt_pkg::M_NUMBER);
					tok_len = ONE_CHAR;
				end else if (is_alpha(c) || c == "_") begin
					begin_token(qlt_pkg::M_IDENT);
					too_long = 1'b0;
					append_word_char(c);
				end else begin
					add_tok(qlt_pkg::K_INVALID, byte_pos, ONE_CHAR);
				end
			end
		endcase
	endtask

	task automatic lex_item(input logic op, input logic [7:0] c);
		bit taken;
		logic [5:0] op_kind;
		taken = 1'b0;
		if (op == CMD_END) begin
			flush_token();
			add_tok(qlt_pkg::K_END, byte_pos, NO_CHARS);
			byte_pos = '0;
		end else begin
			case (lex_mode)
				qlt_pkg::M_STRING: begin
					if (c == (quote_dbl ? 8'("\"") : 8'("'"))) begin
						add_tok(qlt_pkg::K_STRING, tok_start, tok_len);
						lex_mode = qlt_pkg::M_IDLE;
					end else begin
						tok_len = bump(tok_len);
					end
					taken = 1'b1;
				end
				qlt_pkg::M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						append_word_char(c);
						taken = 1'b1;
					end
				end
				qlt_pkg::M_NUMBER: begin
					if (is_digit(c) || c == ".") begin
						tok_len = bump(tok_len);
						taken = 1'b1;
					end
				end
				qlt_pkg::M_LT, qlt_pkg::M_GT, qlt_pkg::M_BANG: begin
					if (c == "=") begin
						if (lex_mode == qlt_pkg::M_LT)
							op_kind = qlt_pkg::K_LE;
						else if (lex_mode == qlt_pkg::M_GT)
							op_kind = qlt_pkg::K_GE;
						else
							op_kind = qlt_pkg::K_NE;
						add_tok(op_kind, tok_start, TWO_CHARS);
						lex_mode = qlt_pkg::M_IDLE;
						taken = 1'b1;
					end
				end
				default: ;
			endcase
			if (!taken) begin
				flush_token();
				idle_char(c);
			end
			byte_pos = bump(byte_pos);
		end
	endtask

	task automatic check_tok();
		qlt_pkg::tok_t want;
		if (expected_toks.size() == 0) begin
			$error("token with none expected: kind %0d start_res %0d length %0d last %0b",
				kind, start_res, length, last);
			errors++;
		end else begin
			want = expected_toks.pop_front();
			if (kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (start_res !== want.start) begin
				$error("start_res: expected %0d, got %0d", want.start, start_res);
				errors++;
			end
			if (length !== want.len) begin
				$error("length: expected %0d, got %0d", want.len, length);
				errors++;
			end
			if (last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, last);
				errors++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode = qlt_pkg::M_IDLE;
			quote_dbl = 1'b0;
			tok_start = '0;
			tok_len = '0;
			byte_pos = '0;
			too_long = 1'b0;
			for (int i = 0; i < qlt_pkg::KW_CHARS; i++)
				word_chars[i] = '0;
			expected_toks.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_tok();
			if (in_valid && in_ready) begin
				item_tok_cnt = 0;
				lex_item(cmd, ch);
				// last marks the final token of this item
				for (int i = 0; i < item_tok_cnt; i++) begin
					item_toks[i].last = (i == item_tok_cnt - 1);
					expected_toks.insert(expected_toks.size(), item_toks[i]);
				end
			end
			pending <= expected_toks.size();
		end
	end

endmodule

/* tb/testbench.sv */
// top of the query language tokenizer testbench: stimulus, idling and verdict
`timescale 1ns / 100ps

module testbench;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_TEXT    = 40;
	localparam int TAIL_CYCLES  = 10;
	// about 1100 items of at most two tokens; the slowest phase stalls the receiver most of the time
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        cmd = 1'b0;
	logic [7:0]  ch = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [5:0]  kind;
	logic [15:0] start_res;
	logic [15:0] length;
	logic        last;

	int errors;
	int pending;
	int send_idle = 17;
	int recv_idle = 87;
	int items_sent = 0;
	int cycle_count = 0;

	logic [7:0] text_q[$];

	query_language_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.ch        (ch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.start_res (start_res),
		.length    (length),
		.last      (last)
	);

	tokenizer_checker tok_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.ch        (ch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.start_res (start_res),
		.length    (length),
		.last      (last),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[query_language_tokenizer] ERROR");
			$finish;
		end
	end

	function automatic string keyword_name(input int k);
		case (k)
			0:  return "SELECT";
			1:  return "FROM";
			2:  return "WHERE";
			3:  return "AND";
			4:  return "OR";
			5:  return "ORDER";
			6:  return "BY";
			7:  return "LIMIT";
			8:  return "ASC";
			9:  return "DESC";
			10: return "IS";
			11: return "NOT";
			12: return "NULL";
			13: return "LIKE";
			14: return "SET";
			15: return "SHOW";
			16: return "XSD";
			17: return "DEST";
			18: return "GENERATE";
			19: return "XML";
			20: return "PREFIX";
			default: return "CHECK";
		endcase
	endfunction

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(1))
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [7:0] word_char(input bit first);
		int r;
		r = $urandom_range(0, first ? 52 : 62);
		if (r < 26)
			return 8'("A") + 8'(r);
		if (r < 52)
			return 8'("a") + 8'(r - 26);
		if (r == 52)
			return "_";
		return 8'("0") + 8'(r - 53);
	endfunction

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 0) ? 8'(" ") : 8'(8 + r);
	endfunction

	task automatic add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(8'(s[i]));
	endtask

	task automatic put_keyword();
		string s;
		s = keyword_name($urandom_range(0, 21));
		for (int i = 0; i < s.len(); i++)
			add_byte(mixed_case(8'(s[i])));
	endtask

	task automatic put_word();
		string s;
		int n;
		if ($urandom_range(1)) begin
			// near miss of a keyword: one character more or one fewer
			s = keyword_name($urandom_range(0, 21));
			n = $urandom_range(1) ? s.len() + 1 : s.len() - 1;
			for (int i = 0; i < n; i++)
				add_byte(mixed_case(i < s.len() ? 8'(s[i]) : word_char(1'b0)));
		end else begin
			n = $urandom_range(1, 12);
			add_byte(word_char(1'b1));
			for (int i = 1; i < n; i++)
				add_byte(word_char(1'b0));
		end
	endtask

	task automatic put_number();
		add_byte(8'("0") + 8'($urandom_range(0, 9)));
		repeat ($urandom_range(0, 4))
			add_byte($urandom_range(3) == 0 ? 8'(".") : 8'("0") + 8'($urandom_range(0, 9)));
	endtask

	task automatic put_quoted(output bit open_string);
		logic [7:0] q;
		logic [7:0] c;
		q = $urandom_range(1) ? 8'("\"") : 8'("'");
		add_byte(q);
		repeat ($urandom_range(0, 6)) begin
			c = 8'($urandom_range(0, 255));
			while (c == q)
				c = 8'($urandom_range(0, 255));
			add_byte(c);
		end
		open_string = ($urandom_range(0, 9) == 0);
		if (!open_string)
			add_byte(q);
	endtask

	task automatic put_operator();
		case ($urandom_range(0, 6))
			0: put_str("<");
			1: put_str("<=");
			2: put_str(">");
			3: put_str(">=");
			4: put_str("=");
			5: put_str("!=");
			default: put_str("!");
		endcase
	endtask

	task automatic put_punct();
		case ($urandom_range(0, 4))
			0: put_str(".");
			1: put_str("/");
			2: put_str(",");
			3: put_str("(");
			default: put_str(")");
		endcase
	endtask

	task automatic build_text();
		int n;
		int pick;
		bit open_string;
		text_q.delete();
		open_string = 1'b0;
		n = $urandom_range(1, 8);
		for (int t = 0; t < n && !open_string; t++) begin
			repeat ($urandom_range(0, 2))
				add_byte(blank_char());
			pick = $urandom_range(0, 99);
			if (pick < 25)
				put_keyword();
			else if (pick < 40)
				put_word();
			else if (pick < 52)
				put_number();
			else if (pick < 64)
				put_quoted(open_string);
			else if (pick < 80)
				put_operator();
			else if (pick < 90)
				put_punct();
			else
				add_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// holds valid and payload until the item is taken
	task automatic send_item(input logic c, input logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		ch <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_item(CMD_CHAR, text_q[i]);
		send_item(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int s_idle, input int r_idle);
		int goal;
		send_idle = s_idle;
		recv_idle = r_idle;
		goal = items_sent + RANDOM_ITEMS / 3;
		while (items_sent < goal) begin
			build_text();
			send_text();
		end
		drain();
	endtask

	// one long string of random bytes, closed, then the bytes x9< and the end item
	task automatic long_text();
		logic [7:0] c;
		send_item(CMD_CHAR, "'");
		repeat (LONG_TEXT) begin
			c = 8'($urandom_range(0, 255));
			if (c == "'")
				c = "a";
			send_item(CMD_CHAR, c);
		end
		send_item(CMD_CHAR, "'");
		text_q.delete();
		put_str("x9<");
		send_text();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operators, quotes of both kinds, high bytes, lone bang, open string at end
		text_q.delete();
		put_str("x<=>9.!'");
		add_byte(8'hff);
		put_str("\"'");
		add_byte(8'h80);
		put_str(",()/=>=<");
		add_byte(8'h00);
		put_str("\t!\"z");
		send_text();
		// empty text
		text_q.delete();
		send_text();
		drain();

		random_phase(17, 87);
		random_phase(87, 17);
		random_phase(0, 0);

		long_text();
		drain();
		// next text must start again at offset zero
		build_text();
		send_text();
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("[query_language_tokenizer] OK");
		else
			$display("[query_language_tokenizer] ERROR");
		$finish;
	end

endmodule
